// ----- hdl/bchpd_pkg.sv -----
// Shared types, constants and table builders for the BCH(31,21) paging decoder.
// Used by bchpd_front, bchpd_queue, bchpd_back and the top level.
package bchpd_pkg;

  localparam int unsigned DATA_BITS   = 21;
  localparam int unsigned CHECK_BITS  = 10;
  localparam int unsigned CW_BITS     = 32;
  localparam int unsigned PARITY_POS  = 31;
  localparam int unsigned CHECK_LSB   = 21;
  localparam int unsigned ROM_DEPTH   = 1024;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [9:0] POLY_SEED    = 10'h3B4;
  localparam logic [9:0] NO_FLIP_PAIR = 10'h3FF;
  localparam logic [4:0] NO_POS       = 5'h1F;

  // Error count codes, also the upper field of a correction table entry.
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_SAT  = 2'd3;

  // Table entry: [13:12] count, [9:5] second position, [4:0] first position.
  typedef logic [13:0] rom_entry_t;
  typedef logic [DATA_BITS-1:0][CHECK_BITS-1:0] chk_tab_t;
  typedef rom_entry_t [ROM_DEPTH-1:0] rom_tab_t;

  typedef struct packed {
    logic [CW_BITS-1:0]    codeword;
    logic [CHECK_BITS-1:0] dsyn;
    logic                  par;
    logic                  syn_nz;
    rom_entry_t            entry;
  } front_item_t;

  function automatic chk_tab_t build_chk();
    chk_tab_t   c;
    logic [9:0] sr;
    sr = POLY_SEED;
    for (int a = 0; a < DATA_BITS; a++) begin
      c[a] = sr;
      if (sr[0]) begin
        sr = (sr >> 1) ^ POLY_SEED;
      end else begin
        sr = sr >> 1;
      end
    end
    return c;
  endfunction

  localparam chk_tab_t CHK = build_chk();

  // Later groups overwrite earlier ones, so keep this order.
  function automatic rom_tab_t build_rom();
    rom_tab_t   r;
    logic [9:0] idx;
    r = '0;
    for (int a = 0; a < DATA_BITS; a++) begin
      for (int b = 0; b < DATA_BITS; b++) begin
        idx = CHK[a] ^ CHK[b];
        r[idx] = {CNT_TWO, 2'b00, b[4:0], a[4:0]};
      end
    end
    for (int a = 0; a < DATA_BITS; a++) begin
      r[CHK[a]] = {CNT_ONE, 2'b00, NO_POS, a[4:0]};
    end
    for (int a = 0; a < DATA_BITS; a++) begin
      for (int b = 0; b < CHECK_BITS; b++) begin
        idx = CHK[a] ^ (10'd1 << b);
        r[idx] = {CNT_TWO, 2'b00, NO_POS, a[4:0]};
      end
    end
    for (int a = 0; a < CHECK_BITS; a++) begin
      idx = 10'd1 << a;
      r[idx] = {CNT_ONE, 2'b00, NO_FLIP_PAIR};
    end
    for (int a = 0; a < CHECK_BITS; a++) begin
      for (int b = 0; b < CHECK_BITS; b++) begin
        if (a != b) begin
          idx = (10'd1 << a) ^ (10'd1 << b);
          r[idx] = {CNT_TWO, 2'b00, NO_FLIP_PAIR};
        end
      end
    end
    return r;
  endfunction

endpackage

// ----- hdl/bchpd_front.sv -----
// Front stage: accepts codewords, forms the syndrome and reads the correction ROM.
// Depends on bchpd_pkg for the check constants, ROM builder and item type.
module bchpd_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [31:0]               codeword_i,
  output logic                      push_o,
  input  logic                      push_ready_i,
  output bchpd_pkg::front_item_t    item_o
);
  import bchpd_pkg::*;

  localparam rom_tab_t ROM = build_rom();

  logic                  f_valid_q, f_valid_d;
  logic                  accept;
  logic [CHECK_BITS-1:0] dsyn, rcv, syn;
  logic                  dpar;
  front_item_t           item_q;

  always_comb begin
    dsyn = '0;
    for (int i = 0; i < DATA_BITS; i++) begin
      if (codeword_i[i]) begin
        dsyn = dsyn ^ CHK[i];
      end
    end
    // position 21 is the most significant check bit
    for (int k = 0; k < CHECK_BITS; k++) begin
      rcv[CHECK_BITS-1-k] = codeword_i[CHECK_LSB+k];
    end
    syn  = dsyn ^ rcv;
    dpar = ^codeword_i[DATA_BITS-1:0];
  end

  assign push_o     = f_valid_q && push_ready_i;
  assign in_ready_o = !f_valid_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    f_valid_d = f_valid_q;
    if (accept) begin
      f_valid_d = 1'b1;
    end else if (push_o) begin
      f_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  // registered ROM read, addressed by the fresh syndrome
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.codeword <= codeword_i;
      item_q.dsyn     <= dsyn;
      item_q.par      <= dpar;
      item_q.syn_nz   <= (syn != '0);
      item_q.entry    <= ROM[syn];
    end
  end

  assign item_o = item_q;

endmodule

// ----- hdl/bchpd_queue.sv -----
// Short FIFO of classified items between the front and back stages.
// Depends on bchpd_pkg for the item type.
module bchpd_queue #(
  parameter int unsigned QueueDepth = bchpd_pkg::QUEUE_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  output logic                      push_ready_o,
  input  bchpd_pkg::front_item_t    item_i,
  output logic                      head_valid_o,
  input  logic                      pop_i,
  output bchpd_pkg::front_item_t    head_o
);
  import bchpd_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  front_item_t     mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign push_ready_o = (count_q != FullCnt);
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != FullCnt))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue pop while empty");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count lost a push");

endmodule

// ----- hdl/bchpd_back.sv -----
// Back stage: applies the ROM correction, runs the parity test, registers the result.
// Depends on bchpd_pkg for the check constants, count codes and item type.
module bchpd_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      head_valid_i,
  input  bchpd_pkg::front_item_t    head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [31:0]               corrected_codeword_o,
  output logic [20:0]               data_word_o,
  output logic [1:0]                error_count_o,
  output logic                      uncorrectable_o
);
  import bchpd_pkg::*;

  logic                  o_valid_q, o_valid_d;
  logic [4:0]            p1, p2;
  logic [1:0]            rom_cnt;
  logic [CW_BITS-1:0]    cw;
  logic [CHECK_BITS-1:0] ds;
  logic                  par;
  logic [1:0]            errs;
  logic [CW_BITS-1:0]    cw_q;
  logic [1:0]            errs_q;

  assign p1      = head_i.entry[4:0];
  assign p2      = head_i.entry[9:5];
  assign rom_cnt = head_i.entry[13:12];

  always_comb begin
    cw   = head_i.codeword;
    ds   = head_i.dsyn;
    par  = head_i.par;
    errs = CNT_NONE;
    if (head_i.syn_nz) begin
      if (head_i.entry != '0) begin
        if (p2 < 5'(DATA_BITS)) begin
          cw[p2] = ~cw[p2];
          ds     = ds ^ CHK[p2];
        end
        if (p1 < 5'(DATA_BITS)) begin
          cw[p1] = ~cw[p1];
          ds     = ds ^ CHK[p1];
        end
        errs = rom_cnt;
      end else begin
        errs = CNT_SAT;
      end
      if (errs == CNT_ONE) begin
        par = ~par;
      end
    end
    par = par ^ (^ds);
    // parity mismatch adds an error, saturating
    if (par != cw[PARITY_POS] && errs != CNT_SAT) begin
      errs = errs + 1'b1;
    end
  end

  assign pop_o = head_valid_i && (!o_valid_q || out_ready_i);

  always_comb begin
    o_valid_d = o_valid_q;
    if (pop_o) begin
      o_valid_d = 1'b1;
    end else if (out_ready_i) begin
      o_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else begin
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cw_q   <= cw;
      errs_q <= errs;
    end
  end

  assign out_valid_o          = o_valid_q;
  assign corrected_codeword_o = cw_q;
  assign data_word_o          = ~cw_q[DATA_BITS-1:0];
  assign error_count_o        = errs_q;
  assign uncorrectable_o      = (errs_q == CNT_SAT);

  a_check_bits_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (cw_q[CW_BITS-1:DATA_BITS] == $past(head_i.codeword[CW_BITS-1:DATA_BITS])))
    else $error("correction touched check or parity bits");

  a_clean_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && !head_i.syn_nz) |=> (cw_q == $past(head_i.codeword) && errs_q != CNT_SAT))
    else $error("zero syndrome altered the codeword");

  a_pop_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && !out_ready_i) |-> !pop_o)
    else $error("result overwritten while stalled");

endmodule

// ----- hdl/bch_31_21_parity_decoder.sv -----
// Top level of the BCH(31,21) paging codeword decoder with even parity bit.
// Instantiates bchpd_front, bchpd_queue and bchpd_back; depends on bchpd_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one 32-bit received
//   codeword per transfer. Output channel (out_valid_o / out_ready_i) carries
//   the corrected codeword, the inverted data bits, a saturating error count
//   and the uncorrectable flag, one result per input, in order.
//   Throughput: one codeword per cycle while the receiver does not stall. The
//   syndrome XOR tree and the registered read of the 1024-entry correction ROM
//   sit in the front stage; correction and the parity test sit in the back
//   stage. An accepted codeword passes the front register, the queue and the
//   output register, in that order, before it shows up on the output.
//   Reset clears all valid flags and queue pointers; the ROM is constant,
//   so the block accepts codewords right after reset.
//   When the receiver stalls, the output register holds its result, the
//   queue fills, and once the front register is blocked in_ready_o drops.
module bch_31_21_parity_decoder #(
  parameter int unsigned QueueDepth = bchpd_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] codeword_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] corrected_codeword_o,
  output logic [20:0] data_word_o,
  output logic [1:0]  error_count_o,
  output logic        uncorrectable_o
);
  import bchpd_pkg::*;

  logic        push, push_ready, head_valid, pop;
  front_item_t front_item, head_item;

  bchpd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .codeword_i  (codeword_i),
    .push_o      (push),
    .push_ready_i(push_ready),
    .item_o      (front_item)
  );

  bchpd_queue #(
    .QueueDepth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_ready_o(push_ready),
    .item_i      (front_item),
    .head_valid_o(head_valid),
    .pop_i       (pop),
    .head_o      (head_item)
  );

  bchpd_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .head_valid_i        (head_valid),
    .head_i              (head_item),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .corrected_codeword_o(corrected_codeword_o),
    .data_word_o         (data_word_o),
    .error_count_o       (error_count_o),
    .uncorrectable_o     (uncorrectable_o)
  );

endmodule

// ----- bench/bch_31_21_parity_decoder_test.sv -----
// Self-checking bench for bch_31_21_parity_decoder: directed and random codewords.
// Predicts each decode in SystemVerilog and compares every output transfer in order.
// Depends on bchpd_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module bch_31_21_parity_decoder_test;

  import bchpd_pkg::*;

  typedef struct packed {
    logic [31:0] corrected;
    logic [20:0] data_bits;
    logic [1:0]  err_count;
    logic        uncorr;
  } decode_result_t;

  // One correction table slot: up to two data positions to flip and a count.
  typedef struct {
    bit       used;
    bit [1:0] cnt;
    bit [4:0] pos_a;
    bit [4:0] pos_b;
  } fix_entry_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] codeword_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] corrected_codeword_o;
  logic [20:0] data_word_o;
  logic [1:0]  error_count_o;
  logic        uncorrectable_o;

  bit [9:0]       check_word [DATA_BITS];
  fix_entry_t     fix_table [ROM_DEPTH];
  decode_result_t pending_decodes [$];
  int             fail_count = 0;
  bit             tx_idle_on = 1'b1;
  bit             rx_idle_on = 1'b1;
  int             stall_go = 0;

  bch_31_21_parity_decoder DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .codeword_i           (codeword_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .corrected_codeword_o (corrected_codeword_o),
    .data_word_o          (data_word_o),
    .error_count_o        (error_count_o),
    .uncorrectable_o      (uncorrectable_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Later groups overwrite earlier ones, so the fill order matters.
  function automatic void build_tables();
    bit [9:0] sr;
    bit [9:0] idx;
    sr = POLY_SEED;
    for (int a = 0; a < DATA_BITS; a++) begin
      check_word[a] = sr;
      sr = sr[0] ? ((sr >> 1) ^ POLY_SEED) : (sr >> 1);
    end
    foreach (fix_table[i]) fix_table[i] = '{1'b0, CNT_NONE, 5'd0, 5'd0};
    for (int a = 0; a < DATA_BITS; a++) begin
      for (int b = 0; b < DATA_BITS; b++) begin
        idx = check_word[a] ^ check_word[b];
        fix_table[idx] = '{1'b1, CNT_TWO, a[4:0], b[4:0]};
      end
    end
    for (int a = 0; a < DATA_BITS; a++) begin
      fix_table[check_word[a]] = '{1'b1, CNT_ONE, a[4:0], NO_POS};
    end
    for (int a = 0; a < DATA_BITS; a++) begin
      for (int b = 0; b < CHECK_BITS; b++) begin
        idx = check_word[a] ^ (10'd1 << b);
        fix_table[idx] = '{1'b1, CNT_TWO, a[4:0], NO_POS};
      end
    end
    for (int a = 0; a < CHECK_BITS; a++) begin
      fix_table[10'd1 << a] = '{1'b1, CNT_ONE, NO_POS, NO_POS};
    end
    for (int a = 0; a < CHECK_BITS; a++) begin
      for (int b = 0; b < CHECK_BITS; b++) begin
        if (a != b) begin
          idx = (10'd1 << a) ^ (10'd1 << b);
          fix_table[idx] = '{1'b1, CNT_TWO, NO_POS, NO_POS};
        end
      end
    end
  endfunction

  function automatic bit [9:0] data_syndrome(input logic [20:0] d);
    bit [9:0] s;
    s = '0;
    for (int i = 0; i < DATA_BITS; i++) begin
      if (d[i]) s ^= check_word[i];
    end
    return s;
  endfunction

  function automatic decode_result_t decode_codeword(input logic [31:0] cw_in);
    decode_result_t r;
    logic [31:0]    cw;
    bit [9:0]       dsyn;
    bit [9:0]       rcv;
    bit [9:0]       syn;
    bit             par;
    int             errs;
    fix_entry_t     e;
    cw   = cw_in;
    dsyn = data_syndrome(cw[20:0]);
    par  = ^cw[20:0];
    rcv  = '0;
    // Position 21 is the most significant check bit.
    for (int i = CHECK_LSB; i < CHECK_LSB + CHECK_BITS; i++) rcv = {rcv[8:0], cw[i]};
    syn  = dsyn ^ rcv;
    errs = 0;
    if (syn != 0) begin
      e = fix_table[syn];
      if (e.used) begin
        if (e.pos_b != NO_POS && e.pos_b < DATA_BITS) begin
          cw[e.pos_b] = ~cw[e.pos_b];
          dsyn ^= check_word[e.pos_b];
        end
        if (e.pos_a != NO_POS && e.pos_a < DATA_BITS) begin
          cw[e.pos_a] = ~cw[e.pos_a];
          dsyn ^= check_word[e.pos_a];
        end
        errs = int'(e.cnt);
      end else begin
        errs = 3;
      end
      if (errs == 1) par = ~par;
    end
    // Parity also folds in the data-only syndrome left after correction.
    par = par ^ (^dsyn);
    if (par != cw[PARITY_POS]) errs++;
    if (errs > 3) errs = 3;
    r.corrected = cw;
    r.data_bits = ~cw[20:0];
    r.err_count = errs[1:0];
    r.uncorr    = (errs == 3);
    return r;
  endfunction

  function automatic logic [31:0] encode_data(input logic [20:0] d);
    logic [31:0] cw;
    bit [9:0]    s;
    s = data_syndrome(d);
    cw = '0;
    cw[20:0] = d;
    for (int k = 0; k < CHECK_BITS; k++) cw[CHECK_LSB + k] = s[9 - k];
    cw[PARITY_POS] = (^d) ^ (^s);
    return cw;
  endfunction

  function automatic logic [31:0] flip_random(input logic [31:0] cw, input int n);
    logic [31:0] mask;
    int          p;
    mask = '0;
    while ($countones(mask) < n) begin
      p = $urandom_range(31, 0);
      mask[p] = 1'b1;
    end
    return cw ^ mask;
  endfunction

  task automatic send_codeword(input logic [31:0] cw);
    if (tx_idle_on && $urandom_range(99, 0) < 18) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    codeword_i <= cw;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic report_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h got %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Predict on input transfers, check output transfers against the oldest prediction.
  always @(posedge clk_i) begin
    decode_result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) pending_decodes.push_back(decode_codeword(codeword_i));
      if (out_valid_o && out_ready_i) begin
        if (pending_decodes.size() == 0) begin
          $display("%0t: unexpected result, expected none got %h", $time,
                   corrected_codeword_o);
          fail_count++;
        end else begin
          want = pending_decodes.pop_front();
          report_field("corrected_codeword", want.corrected, corrected_codeword_o);
          report_field("data_word", 32'(want.data_bits), 32'(data_word_o));
          report_field("error_count", 32'(want.err_count), 32'(error_count_o));
          report_field("uncorrectable", 32'(want.uncorr), 32'(uncorrectable_o));
        end
      end
    end
  end

  // Receiver: random stalls plus a long hold-off on request.
  always @(posedge clk_i) begin
    int stall_left;
    int stall_seen;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_go != stall_seen) begin
      stall_seen  = stall_go;
      stall_left  = 300;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !(rx_idle_on && $urandom_range(99, 0) < 18);
    end
  end

  task automatic test_extremes();
    send_codeword(32'h0000_0000);
    send_codeword(32'hFFFF_FFFF);
    send_codeword(32'h8000_0000);
    send_codeword(32'h7FFF_FFFF);
    send_codeword(encode_data(21'h1F_FFFF));
    send_codeword(encode_data(21'h0A_5A5A));
  endtask

  task automatic test_single_errors();
    logic [31:0] cw;
    cw = encode_data(21'h12_3456);
    send_codeword(cw ^ (32'd1 << 0));
    send_codeword(cw ^ (32'd1 << 20));
    send_codeword(cw ^ (32'd1 << 21));
    send_codeword(cw ^ (32'd1 << 30));
    send_codeword(cw ^ (32'd1 << PARITY_POS));
  endtask

  task automatic test_double_errors();
    logic [31:0] cw;
    cw = encode_data(21'h05_4321);
    send_codeword(cw ^ 32'h0010_0001);
    send_codeword(cw ^ 32'h0020_0400);
    send_codeword(cw ^ 32'h4020_0000);
    send_codeword(cw ^ 32'h8000_0800);
  endtask

  // Four and three errors, and a syndrome that lands on an empty table slot.
  task automatic test_uncorrectable();
    logic [31:0] cw;
    int          hole;
    hole = -1;
    for (int i = 1; i < ROM_DEPTH && hole < 0; i++) if (!fix_table[i].used) hole = i;
    cw = encode_data(21'h1F_0F0F);
    send_codeword(cw ^ 32'h0000_0107);
    send_codeword(cw ^ 32'h8060_0000);
    if (hole > 0) begin
      cw = '0;
      for (int k = 0; k < CHECK_BITS; k++) cw[CHECK_LSB + k] = hole[9 - k];
      send_codeword(cw);
      send_codeword(cw | 32'h8000_0000);
    end
  endtask

  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    stall_go++;
    for (int i = 0; i < 20; i++) send_codeword(flip_random(encode_data(21'($urandom)), i % 3));
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random(input int count);
    logic [31:0] cw;
    for (int i = 0; i < count; i++) begin
      // Run a burst with both sides streaming back to back.
      tx_idle_on = !(i >= 800 && i < 1100);
      rx_idle_on = tx_idle_on;
      if ($urandom_range(99, 0) < 70) begin
        cw = flip_random(encode_data(21'($urandom)), $urandom_range(3, 0));
      end else begin
        cw = $urandom;
      end
      send_codeword(cw);
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    build_tables();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_single_errors();
    test_double_errors();
    test_uncorrectable();
    test_backpressure();
    test_random(1950);
    in_valid_i <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
